// ----- hdl/yuvbgr_pkg.sv -----
// yuvbgr_pkg: shared types, codes and constants of the yuv pair to bgr converter
// no dependencies; used by the interfaces, the pipeline stages and the top level
`default_nettype none

package yuvbgr_pkg;

    // sample and result widths
    localparam int BYTE_W      = 8;
    localparam int DIFF_W      = 9;   // chroma minus 128, signed
    localparam int PROD_W      = 18;  // coefficient times chroma difference, signed
    localparam int SHIFT       = 8;
    localparam int SHIFTED_W   = PROD_W - SHIFT;
    localparam int SUM_W       = 11;  // luma plus shifted term, signed

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ORDER = 2'd1;

    // conversion coefficients
    localparam logic signed [9:0] COEF_B    = 10'sd443;
    localparam logic signed [9:0] COEF_G_V  = 10'sd179;
    localparam logic signed [9:0] COEF_G_U  = 10'sd86;
    localparam logic signed [9:0] COEF_R    = 10'sd351;
    localparam logic [BYTE_W-1:0] CHROMA_MID = 8'd128;
    localparam logic [BYTE_W-1:0] CHAN_MAX   = 8'd255;

    typedef enum logic [1:0] {
        PIX_PACKED = 2'd0,
        PIX_FULL   = 2'd1,
        PIX_GREY   = 2'd2
    } pixel_mode_t;

    typedef enum logic [1:0] {
        ORD_YUYV = 2'd0,
        ORD_YVYU = 2'd1,
        ORD_UYVY = 2'd2,
        ORD_VYUY = 2'd3
    } chroma_order_t;

    // live configuration handed to the unpack stage
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] order;
    } cfg_t;

    // raw input item
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic [BYTE_W-1:0] b4;
        logic [BYTE_W-1:0] b5;
    } raw_t;

    // after unpack: two lumas and the shared chroma differences
    typedef struct packed {
        logic [BYTE_W-1:0]        y0;
        logic [BYTE_W-1:0]        y1;
        logic signed [DIFF_W-1:0] du;
        logic signed [DIFF_W-1:0] dv;
    } unpacked_t;

    // after multiply: lumas and the three chroma terms
    typedef struct packed {
        logic [BYTE_W-1:0]        y0;
        logic [BYTE_W-1:0]        y1;
        logic signed [PROD_W-1:0] pb;
        logic signed [PROD_W-1:0] pg;
        logic signed [PROD_W-1:0] pr;
    } product_t;

    // finished pixel pair
    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] g0;
        logic [BYTE_W-1:0] r0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] g1;
        logic [BYTE_W-1:0] r1;
    } bgr_t;

endpackage

`default_nettype wire

// ----- hdl/yuvbgr_if.sv -----
// yuvbgr stream and configuration interfaces
// depends on yuvbgr_pkg for widths
`default_nettype none

// input channel: six sample bytes per item
interface yuvbgr_in_if;
    logic                           valid;
    logic                           ready;
    logic [yuvbgr_pkg::BYTE_W-1:0]  byte_0;
    logic [yuvbgr_pkg::BYTE_W-1:0]  byte_1;
    logic [yuvbgr_pkg::BYTE_W-1:0]  byte_2;
    logic [yuvbgr_pkg::BYTE_W-1:0]  byte_3;
    logic [yuvbgr_pkg::BYTE_W-1:0]  byte_4;
    logic [yuvbgr_pkg::BYTE_W-1:0]  byte_5;

    modport source (output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
                    input ready);
    modport sink   (input valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
                    output ready);
endinterface

// output channel: one bgr pixel pair per item
interface yuvbgr_out_if;
    logic                           valid;
    logic                           ready;
    logic [yuvbgr_pkg::BYTE_W-1:0]  blue_first;
    logic [yuvbgr_pkg::BYTE_W-1:0]  green_first;
    logic [yuvbgr_pkg::BYTE_W-1:0]  red_first;
    logic [yuvbgr_pkg::BYTE_W-1:0]  blue_second;
    logic [yuvbgr_pkg::BYTE_W-1:0]  green_second;
    logic [yuvbgr_pkg::BYTE_W-1:0]  red_second;

    modport source (output valid, blue_first, green_first, red_first,
                    blue_second, green_second, red_second, input ready);
    modport sink   (input valid, blue_first, green_first, red_first,
                    blue_second, green_second, red_second, output ready);
endinterface

// configuration write channel
interface yuvbgr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [yuvbgr_pkg::CFG_INDEX_W-1:0]  index;
    logic [yuvbgr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/yuvbgr_unpack.sv -----
// yuvbgr_unpack: first pipeline stage, picks lumas and chroma by mode and byte order
// depends on yuvbgr_pkg
`default_nettype none

module yuvbgr_unpack (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire yuvbgr_pkg::cfg_t       cfg,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire yuvbgr_pkg::raw_t       up_data,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output yuvbgr_pkg::unpacked_t       dn_data
);

    logic                               valid_reg;
    yuvbgr_pkg::unpacked_t              data_reg;
    yuvbgr_pkg::unpacked_t              data_next;
    logic [yuvbgr_pkg::BYTE_W-1:0]      u_sel;
    logic [yuvbgr_pkg::BYTE_W-1:0]      v_sel;
    logic [yuvbgr_pkg::BYTE_W:0]        u_sum;
    logic [yuvbgr_pkg::BYTE_W:0]        v_sum;

    // chroma averages for 4:4:4, truncated
    assign u_sum = {1'b0, up_data.b1} + {1'b0, up_data.b4};
    assign v_sum = {1'b0, up_data.b2} + {1'b0, up_data.b5};

    // sample selection
    always_comb
    begin
        data_next.y0 = up_data.b0;
        data_next.y1 = up_data.b1;
        u_sel        = yuvbgr_pkg::CHROMA_MID;
        v_sel        = yuvbgr_pkg::CHROMA_MID;
        case (cfg.mode)
            yuvbgr_pkg::PIX_PACKED:
            begin
                case (cfg.order)
                    yuvbgr_pkg::ORD_YUYV:
                    begin
                        data_next.y0 = up_data.b0;
                        u_sel        = up_data.b1;
                        data_next.y1 = up_data.b2;
                        v_sel        = up_data.b3;
                    end
                    yuvbgr_pkg::ORD_YVYU:
                    begin
                        data_next.y0 = up_data.b0;
                        v_sel        = up_data.b1;
                        data_next.y1 = up_data.b2;
                        u_sel        = up_data.b3;
                    end
                    yuvbgr_pkg::ORD_UYVY:
                    begin
                        u_sel        = up_data.b0;
                        data_next.y0 = up_data.b1;
                        v_sel        = up_data.b2;
                        data_next.y1 = up_data.b3;
                    end
                    default:
                    begin
                        v_sel        = up_data.b0;
                        data_next.y0 = up_data.b1;
                        u_sel        = up_data.b2;
                        data_next.y1 = up_data.b3;
                    end
                endcase
            end
            yuvbgr_pkg::PIX_FULL:
            begin
                data_next.y0 = up_data.b0;
                data_next.y1 = up_data.b3;
                u_sel        = u_sum[yuvbgr_pkg::BYTE_W:1];
                v_sel        = v_sum[yuvbgr_pkg::BYTE_W:1];
            end
            default:
            begin
                // grey and the unused mode code
                data_next.y0 = up_data.b0;
                data_next.y1 = up_data.b1;
                u_sel        = yuvbgr_pkg::CHROMA_MID;
                v_sel        = yuvbgr_pkg::CHROMA_MID;
            end
        endcase
        data_next.du = $signed({1'b0, u_sel}) - $signed({1'b0, yuvbgr_pkg::CHROMA_MID});
        data_next.dv = $signed({1'b0, v_sel}) - $signed({1'b0, yuvbgr_pkg::CHROMA_MID});
    end

    // stage moves when empty or when the next stage takes its item
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/yuvbgr_mult.sv -----
// yuvbgr_mult: second pipeline stage, coefficient products of the chroma differences
// depends on yuvbgr_pkg
`default_nettype none

module yuvbgr_mult (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire yuvbgr_pkg::unpacked_t  up_data,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output yuvbgr_pkg::product_t        dn_data
);

    localparam int PW = yuvbgr_pkg::PROD_W;

    logic                               valid_reg;
    yuvbgr_pkg::product_t               data_reg;
    yuvbgr_pkg::product_t               data_next;

    // three chroma terms, green combines both differences
    always_comb
    begin
        data_next.y0 = up_data.y0;
        data_next.y1 = up_data.y1;
        data_next.pb = PW'(yuvbgr_pkg::COEF_B) * PW'(up_data.du);
        data_next.pg = PW'(yuvbgr_pkg::COEF_G_V) * PW'(up_data.dv)
                     + PW'(yuvbgr_pkg::COEF_G_U) * PW'(up_data.du);
        data_next.pr = PW'(yuvbgr_pkg::COEF_R) * PW'(up_data.dv);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/yuvbgr_sat.sv -----
// yuvbgr_sat: third pipeline stage, floor shift, luma add and saturation; output register
// depends on yuvbgr_pkg
`default_nettype none

module yuvbgr_sat (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire yuvbgr_pkg::product_t   up_data,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output yuvbgr_pkg::bgr_t            dn_data
);

    localparam int SW = yuvbgr_pkg::SUM_W;
    localparam int HW = yuvbgr_pkg::SHIFTED_W;
    localparam int BW = yuvbgr_pkg::BYTE_W;

    logic                               valid_reg;
    yuvbgr_pkg::bgr_t                   data_reg;
    yuvbgr_pkg::bgr_t                   data_next;
    logic signed [HW-1:0]               sh_b;
    logic signed [HW-1:0]               sh_g;
    logic signed [HW-1:0]               sh_r;

    // saturate a signed sum to 0..255
    function automatic logic [BW-1:0] clamp(input logic signed [SW-1:0] s);
        logic [BW-1:0] res;
        if (s[SW-1])
        begin
            res = '0;
        end
        else if (s[SW-2:BW] != '0)
        begin
            res = yuvbgr_pkg::CHAN_MAX;
        end
        else
        begin
            res = s[BW-1:0];
        end
        return res;
    endfunction

    // luma plus a signed term
    function automatic logic signed [SW-1:0] add_y(input logic [BW-1:0] y,
                                                    input logic signed [HW-1:0] t);
        logic signed [SW-1:0] res;
        res = $signed({{(SW-BW){1'b0}}, y}) + SW'(t);
        return res;
    endfunction

    // luma minus a signed term
    function automatic logic signed [SW-1:0] sub_y(input logic [BW-1:0] y,
                                                    input logic signed [HW-1:0] t);
        logic signed [SW-1:0] res;
        res = $signed({{(SW-BW){1'b0}}, y}) - SW'(t);
        return res;
    endfunction

    // dropping the low bits of a two's complement value is a floor shift
    assign sh_b = up_data.pb[yuvbgr_pkg::PROD_W-1:yuvbgr_pkg::SHIFT];
    assign sh_g = up_data.pg[yuvbgr_pkg::PROD_W-1:yuvbgr_pkg::SHIFT];
    assign sh_r = up_data.pr[yuvbgr_pkg::PROD_W-1:yuvbgr_pkg::SHIFT];

    always_comb
    begin
        data_next.b0 = clamp(add_y(up_data.y0, sh_b));
        data_next.g0 = clamp(sub_y(up_data.y0, sh_g));
        data_next.r0 = clamp(add_y(up_data.y0, sh_r));
        data_next.b1 = clamp(add_y(up_data.y1, sh_b));
        data_next.g1 = clamp(sub_y(up_data.y1, sh_g));
        data_next.r1 = clamp(add_y(up_data.y1, sh_r));
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/yuv_pair_to_bgr_converter.sv -----
// yuv_pair_to_bgr_converter: top level, configuration registers and three-stage pipeline
// depends on yuvbgr_pkg, yuvbgr_if, yuvbgr_unpack, yuvbgr_mult, yuvbgr_sat
//
// usage:
// - yuv carries one pixel pair per item as six sample bytes; bgr returns one
//   item per input item with blue, green and red of both pixels, in order
// - cfg writes pixel_mode (index 0) and chroma_order (index 1); cfg.ready is
//   always high, writes to other indexes are dropped; write only while idle
// - each input item passes the unpack, multiply, and shift and saturate stage
//   registers in turn; throughput is one item per cycle while bgr.ready is high
// - the saturate stage register drives bgr directly
// - when bgr.ready is low, the pipeline keeps filling until every stage holds
//   an item, then yuv.ready drops; nothing is lost or repeated
// - yuv.ready is high whenever the output stage is empty or being drained
// - reset clears all stage valid bits and sets both registers to 0 (packed
//   4:2:2, YUYV order)
`default_nettype none

module yuv_pair_to_bgr_converter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    yuvbgr_in_if.sink   yuv,
    yuvbgr_out_if.source bgr,
    yuvbgr_cfg_if.sink  cfg
);

    logic [1:0]                 mode_reg;
    logic [1:0]                 order_reg;
    yuvbgr_pkg::cfg_t           cfg_live;
    yuvbgr_pkg::raw_t           raw;
    yuvbgr_pkg::unpacked_t      s1_data;
    yuvbgr_pkg::product_t       s2_data;
    yuvbgr_pkg::bgr_t           s3_data;
    logic                       s1_valid;
    logic                       s1_ready;
    logic                       s2_valid;
    logic                       s2_ready;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= yuvbgr_pkg::PIX_PACKED;
            order_reg <= yuvbgr_pkg::ORD_YUYV;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == yuvbgr_pkg::CFG_IDX_MODE)
            begin
                mode_reg <= cfg.data;
            end
            else if (cfg.index == yuvbgr_pkg::CFG_IDX_ORDER)
            begin
                order_reg <= cfg.data;
            end
        end
    end

    assign cfg_live.mode  = mode_reg;
    assign cfg_live.order = order_reg;

    // input payload
    assign raw.b0 = yuv.byte_0;
    assign raw.b1 = yuv.byte_1;
    assign raw.b2 = yuv.byte_2;
    assign raw.b3 = yuv.byte_3;
    assign raw.b4 = yuv.byte_4;
    assign raw.b5 = yuv.byte_5;

    // pipeline stages
    yuvbgr_unpack u_unpack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_live),
        .up_valid (yuv.valid),
        .up_ready (yuv.ready),
        .up_data  (raw),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    yuvbgr_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    yuvbgr_sat u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (bgr.valid),
        .dn_ready (bgr.ready),
        .dn_data  (s3_data)
    );

    // output payload
    assign bgr.blue_first   = s3_data.b0;
    assign bgr.green_first  = s3_data.g0;
    assign bgr.red_first    = s3_data.r0;
    assign bgr.blue_second  = s3_data.b1;
    assign bgr.green_second = s3_data.g1;
    assign bgr.red_second   = s3_data.r1;

endmodule

`default_nettype wire

// ----- hdl/yuvbgr_checker.sv -----
// yuvbgr_checker: port-level assertions for the converter, bound to the top level
// depends on yuv_pair_to_bgr_converter and yuvbgr_pkg
`default_nettype none

module yuvbgr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [6*yuvbgr_pkg::BYTE_W-1:0] out_payload
);

    // an item offered on the output stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // a stalled output item keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_payload))
        else $error("output item changed while stalled");

    // with the output stage empty the whole pipeline can take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with empty output stage");

    // an accepted item passes the unpack, multiply and saturate registers to the output with no stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready) |=> out_valid)
        else $error("item missing at output after three cycles");

endmodule

bind yuv_pair_to_bgr_converter yuvbgr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (yuv.valid),
    .in_ready    (yuv.ready),
    .out_valid   (bgr.valid),
    .out_ready   (bgr.ready),
    .out_payload ({bgr.blue_first, bgr.green_first, bgr.red_first,
                   bgr.blue_second, bgr.green_second, bgr.red_second})
);

`default_nettype wire
